### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on a clocked design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rb2d_pkg.sv
// ----------------------------------------------------------------------------
// rb2d_pkg
// Types, constants and helper functions for the 2D rigid body integrator.
// ----------------------------------------------------------------------------
package rb2d_pkg;

	localparam int WORD_W = 32;              // state and field word
	localparam int FRAC_W = 16;              // Q16.16 fraction bits
	localparam int DT_W   = 16;              // Q0.16 step length
	localparam int MUL_W  = WORD_W + 1;      // multiplier operand, holds unsigned words
	localparam int PROD_W = 2 * MUL_W;       // full product
	localparam int DEN_W  = WORD_W + 1;      // drag divisor 1.0 + drag*dt
	localparam int REM_W  = DEN_W;
	localparam int DIV_STEPS = WORD_W;       // quotient bits
	localparam int CNT_W  = $clog2(DIV_STEPS);
	localparam int IDX_W  = 2;               // config register index
	localparam int K_W    = 2;               // component index x, y, angle

	localparam logic [DEN_W-1:0] ONE_Q = DEN_W'(1) << FRAC_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic        [WORD_W-1:0] uword_t;

	typedef enum logic [1:0] {
		OP_FORCE    = 2'd0,
		OP_IMPULSE  = 2'd1,
		OP_VELOCITY = 2'd2,
		OP_STEP     = 2'd3
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_INV_MASS    = 2'd0,
		REG_INV_INERTIA = 2'd1,
		REG_LIN_DRAG    = 2'd2,
		REG_ANG_DRAG    = 2'd3
	} reg_idx_t;

	typedef enum logic [K_W-1:0] {
		K_X     = 2'd0,
		K_Y     = 2'd1,
		K_ANGLE = 2'd2
	} comp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LEVER,
		ST_CR_A,
		ST_CR_B,
		ST_CR_SUM,
		ST_APPLY,
		ST_IMP_MUL,
		ST_IMP_ADD,
		ST_POS_MUL,
		ST_POS_ADD,
		ST_FRC_MUL,
		ST_FRC_HI,
		ST_FRC_LO,
		ST_FRC_ADD,
		ST_DRG_MUL,
		ST_DRG_DEN,
		ST_DIV,
		ST_DIV_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [WORD_W-1:0] vector_x;
		logic signed [WORD_W-1:0] vector_y;
		logic signed [WORD_W-1:0] point_x;
		logic signed [WORD_W-1:0] point_y;
		logic        [DT_W-1:0]   delta_time;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] position_x;
		logic signed [WORD_W-1:0] position_y;
		logic signed [WORD_W-1:0] angle;
		logic signed [WORD_W-1:0] velocity_x;
		logic signed [WORD_W-1:0] velocity_y;
		logic signed [WORD_W-1:0] spin_rate;
	} out_item_t;

	// Sign-extend a word to product width.
	function automatic logic signed [PROD_W-1:0] ext_word(input word_t v);
		return {{(PROD_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

	// Clamp a wide signed value to the word range.
	function automatic word_t sat_word(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-WORD_W:0] hi;
		hi = v[PROD_W-1:WORD_W-1];
		if (hi == '0 || hi == '1) begin
			return v[WORD_W-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

### hdl/rigid_body_2d_integrator.sv
// ----------------------------------------------------------------------------
// rigid_body_2d_integrator
// Keeps position, angle, velocities and accumulated force/torque of one 2D
// rigid body in Q16.16 and returns the body state after every item. One
// 33x33 multiplier and one bit-serial divider are shared under a sequencer,
// and in_ready is high only between items. A time step spends most of its
// time in the drag divider, which retires one quotient bit per cycle for
// each of x, y and angular velocity in turn. A finished result sits in the
// output register, so the next item is taken while the previous result
// waits for out_ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rigid_body_2d_integrator
	import rb2d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	state_t state_q, state_d;

	uword_t inv_mass_q, inv_inertia_q, lin_drag_q, ang_drag_q;

	word_t pos_q [3];
	word_t vel_q [3];
	word_t frc_q [3];

	in_item_t  item_q;
	comp_t     k_q;
	word_t     rx_q, ry_q, c_q;
	logic [DT_W-1:0] bl_q;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic [DEN_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	uword_t dq_q;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q;

	logic      out_valid_q;
	out_item_t out_q;
	logic      out_load;

	// component selection
	word_t  vec_k, vel_k, pos_k, frc_k;
	uword_t gain_k, drag_k, mag_k;

	// divider step
	logic [REM_W:0]   div_r2;
	logic             div_ge;
	logic [REM_W:0]   div_diff;

	always_comb begin
		unique case (k_q)
			K_X: begin
				vec_k  = item_q.vector_x;
				vel_k  = vel_q[0];
				pos_k  = pos_q[0];
				frc_k  = frc_q[0];
				gain_k = inv_mass_q;
				drag_k = lin_drag_q;
			end
			K_Y: begin
				vec_k  = item_q.vector_y;
				vel_k  = vel_q[1];
				pos_k  = pos_q[1];
				frc_k  = frc_q[1];
				gain_k = inv_mass_q;
				drag_k = lin_drag_q;
			end
			K_ANGLE: begin
				vec_k  = c_q;
				vel_k  = vel_q[2];
				pos_k  = pos_q[2];
				frc_k  = frc_q[2];
				gain_k = inv_inertia_q;
				drag_k = ang_drag_q;
			end
			default: begin
				vec_k  = '0;
				vel_k  = '0;
				pos_k  = '0;
				frc_k  = '0;
				gain_k = '0;
				drag_k = '0;
			end
		endcase
		mag_k = vel_k[WORD_W-1] ? uword_t'(-vel_k) : uword_t'(vel_k);
	end

	always_comb begin
		div_r2   = {rem_q, dq_q[WORD_W-1]};
		div_ge   = div_r2 >= {1'b0, den_q};
		div_diff = div_r2 - {1'b0, den_q};
	end

	assign out_load = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_item.operation == OP_STEP) ? ST_POS_MUL : ST_LEVER;
				end
			end
			ST_LEVER:   state_d = ST_CR_A;
			ST_CR_A:    state_d = ST_CR_B;
			ST_CR_B:    state_d = ST_CR_SUM;
			ST_CR_SUM: begin
				state_d = (item_q.operation == OP_IMPULSE) ? ST_IMP_MUL : ST_APPLY;
			end
			ST_APPLY:   state_d = ST_DONE;
			ST_IMP_MUL: state_d = ST_IMP_ADD;
			ST_IMP_ADD: state_d = (k_q == K_ANGLE) ? ST_DONE : ST_IMP_MUL;
			ST_POS_MUL: state_d = ST_POS_ADD;
			ST_POS_ADD: state_d = (k_q == K_ANGLE) ? ST_FRC_MUL : ST_POS_MUL;
			ST_FRC_MUL: state_d = ST_FRC_HI;
			ST_FRC_HI:  state_d = ST_FRC_LO;
			ST_FRC_LO:  state_d = ST_FRC_ADD;
			ST_FRC_ADD: state_d = ST_DRG_MUL;
			ST_DRG_MUL: state_d = ST_DRG_DEN;
			ST_DRG_DEN: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: state_d = (k_q == K_ANGLE) ? ST_DONE : ST_FRC_MUL;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and multiplier operands
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_CR_A: begin
				mul_a = MUL_W'(rx_q);
				mul_b = MUL_W'(item_q.vector_y);
			end
			ST_CR_B: begin
				mul_a = MUL_W'(ry_q);
				mul_b = MUL_W'(item_q.vector_x);
			end
			ST_IMP_MUL: begin
				mul_a = MUL_W'(vec_k);
				mul_b = {1'b0, gain_k};
			end
			ST_POS_MUL: begin
				mul_a = MUL_W'(vel_k);
				mul_b = {{(MUL_W-DT_W){1'b0}}, item_q.delta_time};
			end
			ST_FRC_MUL: begin
				mul_a = MUL_W'(frc_k);
				mul_b = {1'b0, gain_k};
			end
			ST_FRC_HI: begin
				// high part of floor(force*gain / 2^16)
				mul_a = MUL_W'($signed(prod_q[2*FRAC_W+WORD_W-1:2*FRAC_W]));
				mul_b = {{(MUL_W-DT_W){1'b0}}, item_q.delta_time};
			end
			ST_FRC_LO: begin
				mul_a = {{(MUL_W-FRAC_W){1'b0}}, bl_q};
				mul_b = {{(MUL_W-DT_W){1'b0}}, item_q.delta_time};
			end
			ST_DRG_MUL: begin
				mul_a = {1'b0, drag_k};
				mul_b = {{(MUL_W-DT_W){1'b0}}, item_q.delta_time};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q    <= '0;
			inv_inertia_q <= '0;
			lin_drag_q    <= '0;
			ang_drag_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INV_MASS:    inv_mass_q    <= cfg_data;
				REG_INV_INERTIA: inv_inertia_q <= cfg_data;
				REG_LIN_DRAG:    lin_drag_q    <= cfg_data;
				REG_ANG_DRAG:    ang_drag_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Body state and component index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_X;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				frc_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= K_X;
				end
				ST_APPLY: begin
					if (item_q.operation == OP_FORCE) begin
						frc_q[0] <= sat_word(ext_word(frc_q[0]) + ext_word(item_q.vector_x));
						frc_q[1] <= sat_word(ext_word(frc_q[1]) + ext_word(item_q.vector_y));
						frc_q[2] <= sat_word(ext_word(frc_q[2]) + ext_word(c_q));
					end else begin
						vel_q[0] <= sat_word(ext_word(vel_q[0]) + ext_word(item_q.vector_x));
						vel_q[1] <= sat_word(ext_word(vel_q[1]) + ext_word(item_q.vector_y));
						vel_q[2] <= sat_word(ext_word(vel_q[2]) + ext_word(c_q));
					end
				end
				ST_IMP_ADD: begin
					vel_q[k_q] <= sat_word(ext_word(vel_k) + (prod_q >>> FRAC_W));
					k_q        <= comp_t'(k_q + 1'b1);
				end
				ST_POS_ADD: begin
					pos_q[k_q] <= sat_word(ext_word(pos_k) + (prod_q >>> FRAC_W));
					k_q        <= (k_q == K_ANGLE) ? K_X : comp_t'(k_q + 1'b1);
				end
				ST_FRC_ADD: begin
					vel_q[k_q] <= sat_word(acc_q + (prod_q >>> FRAC_W));
				end
				ST_DIV_END: begin
					vel_q[k_q] <= neg_q ? word_t'(-dq_q) : word_t'(dq_q);
					k_q        <= comp_t'(k_q + 1'b1);
					if (k_q == K_ANGLE) begin
						// step done: drop accumulated force and torque
						for (int i = 0; i < 3; i++) begin
							frc_q[i] <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					item_q <= in_item;
				end
			end
			ST_LEVER: begin
				rx_q <= sat_word(ext_word(item_q.point_x) - ext_word(pos_q[0]));
				ry_q <= sat_word(ext_word(item_q.point_y) - ext_word(pos_q[1]));
			end
			ST_CR_B: begin
				acc_q <= prod_q;
			end
			ST_CR_SUM: begin
				c_q <= sat_word((acc_q - prod_q) >>> FRAC_W);
			end
			ST_FRC_HI: begin
				bl_q <= prod_q[2*FRAC_W-1:FRAC_W];
			end
			ST_FRC_LO: begin
				acc_q <= prod_q + ext_word(vel_k);
			end
			ST_DRG_DEN: begin
				den_q <= {1'b0, prod_q[WORD_W+FRAC_W-1:FRAC_W]} + ONE_Q;
				neg_q <= vel_k[WORD_W-1];
				// top quotient bits are zero since the divisor is at least 1.0
				rem_q <= REM_W'(mag_k[WORD_W-1:FRAC_W]);
				dq_q  <= {mag_k[FRAC_W-1:0], {(WORD_W-FRAC_W){1'b0}}};
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_diff[REM_W-1:0] : div_r2[REM_W-1:0];
				dq_q  <= {dq_q[WORD_W-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_load) begin
			out_q.position_x <= pos_q[0];
			out_q.position_y <= pos_q[1];
			out_q.angle      <= pos_q[2];
			out_q.velocity_x <= vel_q[0];
			out_q.velocity_y <= vel_q[1];
			out_q.spin_rate  <= vel_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ASSERT_IMPLIES(a_div_den_min, clk, arst_n, state_q == ST_DIV, den_q >= ONE_Q, "drag divisor below 1.0")
	`ASSERT_IMPLIES(a_div_rem_bound, clk, arst_n, state_q == ST_DIV, rem_q < den_q, "divider remainder not below divisor")
	`ASSERT_IMPLIES(a_step_clears, clk, arst_n, state_q == ST_DONE && item_q.operation == OP_STEP, frc_q[0] == '0 && frc_q[1] == '0 && frc_q[2] == '0, "force not cleared after step")
	`ASSERT_NEXT(a_done_loads, clk, arst_n, state_q == ST_DONE && out_load, out_valid && state_q == ST_IDLE, "result not presented after item")

endmodule

### tb/rigid_body_2d_integrator_test.sv
// ----------------------------------------------------------------------------
// rigid_body_2d_integrator_test
// Drives force, impulse, velocity and time step items into the 2D rigid body
// integrator and checks each body state it returns against a Q16.16 model of
// the integrator kept alongside, over several register settings, with random
// idle cycles on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rigid_body_2d_integrator_test;
	import rb2d_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam word_t WORD_HI     = 32'sh7fff_ffff;
	localparam word_t WORD_LO     = 32'sh8000_0000;
	localparam int    QUIET_LIMIT = 3000;
	localparam int    DRAIN_WAIT  = 150;
	localparam int    PHASE_ITEMS = 134;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_item   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_item;

	rigid_body_2d_integrator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Body model: registers, motion state and accumulated loads
	uword_t inv_mass, inv_inertia, lin_drag, ang_drag;
	word_t  body_pos_x, body_pos_y, body_angle;
	word_t  body_vel_x, body_vel_y, body_spin;
	word_t  load_x, load_y, load_torque;

	in_item_t  items_to_send[$];
	out_item_t body_states_due[$];
	int        queued_count   = 0;
	int        accepted_count = 0;
	int        fail_count     = 0;
	int        quiet_cycles   = 0;
	int        send_gap       = 0;
	int        stall_left     = 0;
	bit        in_taken       = 1'b0;
	bit        idle_on        = 1'b1;

	function automatic word_t clamp_word(input wide_t v);
		if (v > wide_t'(WORD_HI)) begin
			return WORD_HI;
		end else if (v < wide_t'(WORD_LO)) begin
			return WORD_LO;
		end
		return word_t'(v);
	endfunction

	// Torque arm cross product: lever from body position to the point, times vector
	function automatic word_t turning_term(input in_item_t it);
		wide_t rx, ry;
		rx = wide_t'(clamp_word(wide_t'(it.point_x) - wide_t'(body_pos_x)));
		ry = wide_t'(clamp_word(wide_t'(it.point_y) - wide_t'(body_pos_y)));
		return clamp_word((rx * wide_t'(it.vector_y) - ry * wide_t'(it.vector_x)) >>> FRAC_W);
	endfunction

	// Divide by 1.0 + drag*dt, truncating toward zero
	function automatic word_t apply_drag(input word_t v, input uword_t coef,
			input logic [DT_W-1:0] dt);
		wide_t den, mag, q;
		den = (wide_t'(1) <<< FRAC_W) + ((wide_t'(coef) * wide_t'(dt)) >>> FRAC_W);
		mag = (v < 0) ? -wide_t'(v) : wide_t'(v);
		q = (mag <<< FRAC_W) / den;
		return (v < 0) ? word_t'(-q) : word_t'(q);
	endfunction

	function automatic out_item_t advance_body(input in_item_t it);
		wide_t     idt;
		word_t     c;
		out_item_t r;
		idt = wide_t'(it.delta_time);
		case (it.operation)
			OP_FORCE: begin
				c = turning_term(it);
				load_x = clamp_word(wide_t'(load_x) + wide_t'(it.vector_x));
				load_y = clamp_word(wide_t'(load_y) + wide_t'(it.vector_y));
				load_torque = clamp_word(wide_t'(load_torque) + wide_t'(c));
			end
			OP_IMPULSE: begin
				c = turning_term(it);
				body_vel_x = clamp_word(wide_t'(body_vel_x)
					+ ((wide_t'(it.vector_x) * wide_t'(inv_mass)) >>> FRAC_W));
				body_vel_y = clamp_word(wide_t'(body_vel_y)
					+ ((wide_t'(it.vector_y) * wide_t'(inv_mass)) >>> FRAC_W));
				body_spin = clamp_word(wide_t'(body_spin)
					+ ((wide_t'(c) * wide_t'(inv_inertia)) >>> FRAC_W));
			end
			OP_VELOCITY: begin
				c = turning_term(it);
				body_vel_x = clamp_word(wide_t'(body_vel_x) + wide_t'(it.vector_x));
				body_vel_y = clamp_word(wide_t'(body_vel_y) + wide_t'(it.vector_y));
				body_spin = clamp_word(wide_t'(body_spin) + wide_t'(c));
			end
			default: begin
				// advance pose with the old velocities first
				body_pos_x = clamp_word(wide_t'(body_pos_x)
					+ ((wide_t'(body_vel_x) * idt) >>> FRAC_W));
				body_pos_y = clamp_word(wide_t'(body_pos_y)
					+ ((wide_t'(body_vel_y) * idt) >>> FRAC_W));
				body_angle = clamp_word(wide_t'(body_angle)
					+ ((wide_t'(body_spin) * idt) >>> FRAC_W));
				body_vel_x = clamp_word(wide_t'(body_vel_x)
					+ ((((wide_t'(load_x) * wide_t'(inv_mass)) >>> FRAC_W) * idt) >>> FRAC_W));
				body_vel_y = clamp_word(wide_t'(body_vel_y)
					+ ((((wide_t'(load_y) * wide_t'(inv_mass)) >>> FRAC_W) * idt) >>> FRAC_W));
				body_spin = clamp_word(wide_t'(body_spin)
					+ ((((wide_t'(load_torque) * wide_t'(inv_inertia)) >>> FRAC_W) * idt)
					>>> FRAC_W));
				body_vel_x = apply_drag(body_vel_x, lin_drag, it.delta_time);
				body_vel_y = apply_drag(body_vel_y, lin_drag, it.delta_time);
				body_spin = apply_drag(body_spin, ang_drag, it.delta_time);
				load_x = '0;
				load_y = '0;
				load_torque = '0;
			end
		endcase
		r.position_x = body_pos_x;
		r.position_y = body_pos_y;
		r.angle      = body_angle;
		r.velocity_x = body_vel_x;
		r.velocity_y = body_vel_y;
		r.spin_rate  = body_spin;
		return r;
	endfunction

	function automatic void compare_field(input string name, input word_t exp_v,
			input word_t got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	function automatic void check_state(input out_item_t exp_s, input out_item_t got_s);
		compare_field("position_x", exp_s.position_x, got_s.position_x);
		compare_field("position_y", exp_s.position_y, got_s.position_y);
		compare_field("angle", exp_s.angle, got_s.angle);
		compare_field("velocity_x", exp_s.velocity_x, got_s.velocity_x);
		compare_field("velocity_y", exp_s.velocity_y, got_s.velocity_y);
		compare_field("spin_rate", exp_s.spin_rate, got_s.spin_rate);
	endfunction

	// Monitor: predict on input accept, check on result accept, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				body_states_due.push_back(advance_body(in_item));
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				if (body_states_due.size() == 0) begin
					$error("body state returned with no item outstanding");
					fail_count++;
				end else begin
					check_state(body_states_due.pop_front(), out_item);
				end
			end
			if (in_taken || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Driver: hold valid until accepted, then take the next item or idle a while
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (items_to_send.size() != 0) begin
				in_item  <= items_to_send.pop_front();
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 14);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side: random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic in_item_t make_item(input op_t op, input word_t vx, input word_t vy,
			input word_t px, input word_t py, input logic [DT_W-1:0] dt);
		in_item_t it;
		it.operation  = op;
		it.vector_x   = vx;
		it.vector_y   = vy;
		it.point_x    = px;
		it.point_y    = py;
		it.delta_time = dt;
		return it;
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return word_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return WORD_HI;
					1: return WORD_LO;
					2: return '0;
					default: return -1;
				endcase
			end
			// mostly a few units either side of zero, so motion stays in range
			default: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic logic [DT_W-1:0] pick_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return DT_W'($urandom_range(0, 16'hffff));
			default: return DT_W'($urandom_range(16'h0100, 16'h1000));
		endcase
	endfunction

	function automatic uword_t pick_reg();
		case ($urandom_range(0, 3))
			0: return uword_t'($urandom);
			default: return uword_t'($urandom_range(0, 32'h0002_0000));
		endcase
	endfunction

	function automatic in_item_t random_item();
		return make_item(op_t'($urandom_range(0, 3)), pick_word(), pick_word(),
			pick_word(), pick_word(), pick_step());
	endfunction

	task automatic queue_item(input in_item_t it);
		items_to_send.push_back(it);
		queued_count++;
	endtask

	// Wait until every queued item is accepted and its state returned
	task automatic drain();
		while (accepted_count != queued_count || body_states_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Call at a falling edge; returns at a falling edge
	task automatic write_reg(input reg_idx_t idx, input uword_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_INV_MASS:    inv_mass    = value;
			REG_INV_INERTIA: inv_inertia = value;
			REG_LIN_DRAG:    lin_drag    = value;
			REG_ANG_DRAG:    ang_drag    = value;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(input uword_t m, input uword_t i, input uword_t ld,
			input uword_t ad);
		write_reg(REG_INV_MASS, m);
		write_reg(REG_INV_INERTIA, i);
		write_reg(REG_LIN_DRAG, ld);
		write_reg(REG_ANG_DRAG, ad);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input uword_t m, input uword_t i, input uword_t ld,
			input uword_t ad);
		drain();
		program_regs(m, i, ld, ad);
		repeat (PHASE_ITEMS) queue_item(random_item());
	endtask

	initial begin
		inv_mass    = '0;
		inv_inertia = '0;
		lin_drag    = '0;
		ang_drag    = '0;
		body_pos_x  = '0;
		body_pos_y  = '0;
		body_angle  = '0;
		body_vel_x  = '0;
		body_vel_y  = '0;
		body_spin   = '0;
		load_x      = '0;
		load_y      = '0;
		load_torque = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		program_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000);

		// forces, the first with a nonzero step field, which it ignores
		queue_item(make_item(OP_FORCE, 32'sh0002_0000, -32'sh0001_0000, '0,
			32'sh0001_0000, 16'hffff));
		queue_item(make_item(OP_FORCE, '0, 32'sh0003_0000, 32'sh0002_0000, '0, '0));
		// zero step only clears the loads; the next step sees none
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, '0));
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, 16'h1000));
		queue_item(make_item(OP_VELOCITY, 32'sh0001_8000, -32'sh0000_8000,
			32'sh0001_0000, 32'sh0001_0000, 16'h1234));
		queue_item(make_item(OP_IMPULSE, -32'sh0002_0000, 32'sh0001_0000,
			-32'sh0001_0000, 32'sh0000_8000, 16'h00ff));
		queue_item(make_item(OP_FORCE, 32'sh0004_0000, 32'sh0004_0000,
			32'sh0003_0000, -32'sh0003_0000, '0));
		// step ignores vector and point fields
		queue_item(make_item(OP_STEP, WORD_HI, WORD_LO, WORD_HI, WORD_LO, 16'h4000));
		queue_item(make_item(OP_STEP, -1, 32'sh1234_5678, WORD_LO, -1, 16'hffff));
		// cross product beyond the word on both signs
		queue_item(make_item(OP_FORCE, WORD_HI, WORD_LO, WORD_HI, WORD_LO, '0));
		queue_item(make_item(OP_FORCE, WORD_LO, WORD_LO, WORD_LO, WORD_HI, '0));
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, 16'hffff));
		queue_item(make_item(OP_VELOCITY, WORD_HI, WORD_HI, WORD_HI, WORD_HI, 16'hffff));
		queue_item(make_item(OP_IMPULSE, WORD_LO, WORD_LO, WORD_LO, WORD_LO, '0));
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, 16'h0001));
		queue_item(make_item(OP_VELOCITY, -1, -1, -1, -1, '0));
		queue_item(make_item(OP_IMPULSE, '0, '0, '0, '0, '0));
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, 16'h8000));
		queue_item(make_item(OP_FORCE, WORD_LO, WORD_HI, -1, '0, 16'h0001));
		queue_item(make_item(OP_STEP, '0, '0, '0, '0, 16'h2000));

		// static body, no drag; then every register at its top
		run_phase('0, '0, '0, '0);
		run_phase('1, '1, '1, '1);
		run_phase(pick_reg(), pick_reg(), pick_reg(), pick_reg());
		run_phase(uword_t'($urandom), uword_t'($urandom), uword_t'($urandom),
			uword_t'($urandom));
		run_phase(pick_reg(), pick_reg(), pick_reg(), pick_reg());

		// last stretch runs with no idling
		drain();
		idle_on = 1'b0;
		program_regs(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000);
		repeat (PHASE_ITEMS) queue_item(random_item());

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && body_states_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/rb2d_pkg.sv
hdl/rigid_body_2d_integrator.sv
tb/rigid_body_2d_integrator_test.sv
